// ----- sv/stq_pkg.sv -----
// Shared types and constants of the sorted timer queue scheduler.
package stq_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned ID_W = 4;
    localparam int unsigned CMD_W = 2;
    localparam int unsigned IN_DATA_W = 72;
    localparam int unsigned IN_USER_W = CMD_W;
    localparam int unsigned OUT_DATA_W = 72;
    localparam int unsigned OUT_USER_W = 3;
    localparam logic [TIME_W-1:0] TIME_ONES = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_START  = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_TICK   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DROP,
        ST_NEXT,
        ST_ELAPSE,
        ST_LEFT,
        ST_DECIDE,
        ST_INSERT,
        ST_FIRE,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        RES_REJECT,
        RES_SCHED,
        RES_NOSCHED,
        RES_QUERY_HIT,
        RES_QUERY_IDLE,
        RES_FIRE
    } t_kind;

    // Controller to datapath.
    typedef struct packed {
        logic  accept;
        logic  rd;
        logic  rd_src_id;
        logic  elapse;
        logic  left;
        logic  head_cap;
        logic  idx_inc;
        logic  drop;
        logic  drop_head;
        logic  insert;
        logic  emit;
        t_kind kind;
    } t_ctl;

    // Datapath to controller.
    typedef struct packed {
        t_cmd cmd;
        logic bad_start;
        logic id_active;
        logic count_zero;
        logic more;
        logic less;
        logic expired;
        logic out_free;
    } t_sts;

endpackage

// ----- sv/stq_ctrl.sv -----
// Command sequencer of the sorted timer queue scheduler.
module stq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  stq_pkg::t_sts i_sts,
    output stq_pkg::t_ctl o_ctl
);

    stq_pkg::t_state r_state, n_state;
    stq_pkg::t_kind  r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stq_pkg::ST_IDLE;
            r_kind  <= stq_pkg::RES_NOSCHED;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_kind          = r_kind;
        o_ctl           = '0;
        o_ctl.kind      = r_kind;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            stq_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_ctl.accept = 1'b1;
                    n_state      = stq_pkg::ST_DISPATCH;
                end
            end
            stq_pkg::ST_DISPATCH: begin
                unique case (i_sts.cmd)
                    stq_pkg::CMD_START: begin
                        if (i_sts.bad_start) begin
                            n_kind  = stq_pkg::RES_REJECT;
                            n_state = stq_pkg::ST_EMIT;
                        end else if (i_sts.id_active) begin
                            n_state = stq_pkg::ST_DROP;
                        end else begin
                            n_state = stq_pkg::ST_NEXT;
                        end
                    end
                    stq_pkg::CMD_CANCEL: begin
                        if (i_sts.id_active) begin
                            n_state = stq_pkg::ST_DROP;
                        end else begin
                            n_kind  = stq_pkg::RES_NOSCHED;
                            n_state = stq_pkg::ST_EMIT;
                        end
                    end
                    stq_pkg::CMD_QUERY: begin
                        if (i_sts.id_active) begin
                            o_ctl.rd        = 1'b1;
                            o_ctl.rd_src_id = 1'b1;
                            n_state         = stq_pkg::ST_ELAPSE;
                        end else begin
                            n_kind  = stq_pkg::RES_QUERY_IDLE;
                            n_state = stq_pkg::ST_EMIT;
                        end
                    end
                    stq_pkg::CMD_TICK: begin
                        if (i_sts.count_zero) begin
                            n_kind  = stq_pkg::RES_SCHED;
                            n_state = stq_pkg::ST_EMIT;
                        end else begin
                            o_ctl.rd = 1'b1;
                            n_state  = stq_pkg::ST_ELAPSE;
                        end
                    end
                endcase
            end
            stq_pkg::ST_DROP: begin
                o_ctl.drop = 1'b1;
                n_state    = stq_pkg::ST_NEXT;
            end
            stq_pkg::ST_NEXT: begin
                if (!i_sts.count_zero) begin
                    o_ctl.rd = 1'b1;
                    n_state  = stq_pkg::ST_ELAPSE;
                end else if (i_sts.cmd == stq_pkg::CMD_START) begin
                    n_state = stq_pkg::ST_INSERT;
                end else begin
                    n_kind  = stq_pkg::RES_SCHED;
                    n_state = stq_pkg::ST_EMIT;
                end
            end
            stq_pkg::ST_ELAPSE: begin
                o_ctl.elapse = 1'b1;
                n_state      = stq_pkg::ST_LEFT;
            end
            stq_pkg::ST_LEFT: begin
                o_ctl.left     = 1'b1;
                o_ctl.head_cap = (i_sts.cmd != stq_pkg::CMD_QUERY);
                n_state        = stq_pkg::ST_DECIDE;
            end
            stq_pkg::ST_DECIDE: begin
                unique case (i_sts.cmd)
                    stq_pkg::CMD_QUERY: begin
                        n_kind  = stq_pkg::RES_QUERY_HIT;
                        n_state = stq_pkg::ST_EMIT;
                    end
                    stq_pkg::CMD_CANCEL: begin
                        n_kind  = stq_pkg::RES_SCHED;
                        n_state = stq_pkg::ST_EMIT;
                    end
                    stq_pkg::CMD_TICK: begin
                        if (i_sts.expired) begin
                            n_state = stq_pkg::ST_FIRE;
                        end else begin
                            n_kind  = stq_pkg::RES_SCHED;
                            n_state = stq_pkg::ST_EMIT;
                        end
                    end
                    stq_pkg::CMD_START: begin
                        if (i_sts.less) begin
                            o_ctl.idx_inc = 1'b1;
                            n_state = i_sts.more ? stq_pkg::ST_NEXT : stq_pkg::ST_INSERT;
                        end else begin
                            n_state = stq_pkg::ST_INSERT;
                        end
                    end
                endcase
            end
            stq_pkg::ST_INSERT: begin
                o_ctl.insert = 1'b1;
                n_kind       = stq_pkg::RES_SCHED;
                n_state      = stq_pkg::ST_EMIT;
            end
            stq_pkg::ST_FIRE: begin
                if (i_sts.out_free) begin
                    o_ctl.emit      = 1'b1;
                    o_ctl.kind      = stq_pkg::RES_FIRE;
                    o_ctl.drop      = 1'b1;
                    o_ctl.drop_head = 1'b1;
                    n_state         = stq_pkg::ST_NEXT;
                end
            end
            stq_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    n_state    = stq_pkg::ST_IDLE;
                end
            end
            default: n_state = stq_pkg::ST_IDLE;
        endcase
    end

endmodule

// ----- sv/stq_dp.sv -----
// Datapath of the sorted timer queue: ordered list, timer memories, time-left unit, result register.
module stq_dp #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [stq_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    input  logic [stq_pkg::IN_USER_W-1:0]      i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [stq_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    output logic [stq_pkg::OUT_USER_W-1:0]     o_m_axis_tuser,
    output logic                               o_m_axis_tlast,
    input  stq_pkg::t_ctl                      i_ctl,
    output stq_pkg::t_sts                      o_sts
);

    localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int TW = stq_pkg::TIME_W;

    // Latched input item.
    stq_pkg::t_cmd     r_cmd;
    logic [stq_pkg::ID_W-1:0] r_id;
    logic [TW-1:0]     r_tmo;
    logic [TW-1:0]     r_now;

    // Ordered list and slot state.
    logic [SW-1:0]         r_order [NUM_TIMERS];
    logic [SW-1:0]         n_order [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_active;
    logic [CW-1:0]         r_count;
    logic [SW-1:0]         r_idx;

    // Timer memories, valid only where r_active is set.
    logic [TW-1:0] r_mem_start [NUM_TIMERS];
    logic [TW-1:0] r_mem_tmo   [NUM_TIMERS];
    logic [TW-1:0] r_rd_start;
    logic [TW-1:0] r_rd_tmo;

    // Time-left unit.
    logic [TW-1:0] r_elapsed;
    logic [TW-1:0] r_tslot;
    logic [TW-1:0] r_left;
    logic [TW-1:0] r_head;
    logic [TW:0]   left_diff;

    logic [SW-1:0]         id_slot;
    logic                  in_range;
    logic [SW-1:0]         rd_addr;
    logic [SW-1:0]         drop_slot;
    logic [NUM_TIMERS-1:0] drop_pre;

    // Result register.
    logic                  r_ovalid;
    logic [stq_pkg::OUT_DATA_W-1:0] r_odata;
    logic [stq_pkg::OUT_USER_W-1:0] r_ouser;
    logic                  r_olast;
    logic                  o_free;

    assign id_slot  = SW'(r_id);
    assign in_range = (int'(r_id) < NUM_TIMERS);
    assign rd_addr  = i_ctl.rd_src_id ? id_slot : r_order[r_idx];
    assign drop_slot = i_ctl.drop_head ? r_order[0] : id_slot;
    assign left_diff = {1'b0, r_tslot} - {1'b0, r_elapsed};
    assign o_free    = !r_ovalid || i_m_axis_tready;

    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.bad_start  = (r_tmo == '0) || (r_tmo == stq_pkg::TIME_ONES) || !in_range;
        o_sts.id_active  = in_range && r_active[id_slot];
        o_sts.count_zero = (r_count == '0);
        o_sts.more       = ((CW+1)'(r_idx) + (CW+1)'(1)) < (CW+1)'(r_count);
        o_sts.less       = (r_left < r_tmo);
        o_sts.expired    = (r_left == '0);
        o_sts.out_free   = o_free;
    end

    // List update: removal shifts the tail left, insertion shifts it right.
    always_comb begin
        logic acc;
        acc     = 1'b0;
        n_order = r_order;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            acc = acc | (r_order[i] == drop_slot);
            drop_pre[i] = acc;
        end
        if (i_ctl.drop) begin
            for (int i = 0; i < NUM_TIMERS - 1; i++) begin
                if (drop_pre[i]) begin
                    n_order[i] = r_order[i+1];
                end
            end
        end else if (i_ctl.insert) begin
            for (int i = 1; i < NUM_TIMERS; i++) begin
                if (i > int'(r_idx)) begin
                    n_order[i] = r_order[i-1];
                end
            end
            n_order[r_idx] = id_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_order <= n_order;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_count  <= '0;
        end else if (i_ctl.drop) begin
            r_active[drop_slot] <= 1'b0;
            r_count             <= r_count - CW'(1);
        end else if (i_ctl.insert) begin
            r_active[id_slot] <= 1'b1;
            r_count           <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd <= stq_pkg::t_cmd'(i_s_axis_tuser[stq_pkg::CMD_W-1:0]);
            r_id  <= i_s_axis_tdata[stq_pkg::ID_W-1:0];
            r_tmo <= i_s_axis_tdata[stq_pkg::ID_W +: TW];
            r_now <= i_s_axis_tdata[stq_pkg::ID_W + TW +: TW];
            r_idx <= '0;
        end else if (i_ctl.idx_inc) begin
            r_idx <= r_idx + SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.insert) begin
            r_mem_start[id_slot] <= r_now;
            r_mem_tmo[id_slot]   <= r_tmo;
        end
        if (i_ctl.rd) begin
            r_rd_start <= r_mem_start[rd_addr];
            r_rd_tmo   <= r_mem_tmo[rd_addr];
        end
    end

    // Elapsed time wraps modulo 2^32; an overdue timer has zero left.
    always_ff @(posedge i_clk) begin
        if (i_ctl.elapse) begin
            r_elapsed <= r_now - r_rd_start;
            r_tslot   <= r_rd_tmo;
        end
        if (i_ctl.left) begin
            r_left <= left_diff[TW] ? '0 : left_diff[TW-1:0];
            if (i_ctl.head_cap && r_idx == '0) begin
                r_head <= left_diff[TW] ? '0 : left_diff[TW-1:0];
            end
        end else if (i_ctl.insert && r_idx == '0) begin
            r_head <= r_tmo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [stq_pkg::ID_W-1:0] f_id;
        logic [TW-1:0]            t_left;
        logic [TW-1:0]            t_next;
        logic                     f_fired;
        logic                     f_status;
        logic                     f_sv;
        if (i_ctl.emit) begin
            f_id     = '0;
            t_left   = '0;
            t_next   = '0;
            f_fired  = 1'b0;
            f_status = 1'b0;
            f_sv     = 1'b0;
            case (i_ctl.kind)
                stq_pkg::RES_REJECT:     f_status = 1'b1;
                stq_pkg::RES_SCHED: begin
                    f_sv   = 1'b1;
                    t_next = (r_count == '0) ? stq_pkg::TIME_ONES : r_head;
                end
                stq_pkg::RES_QUERY_HIT:  t_left = r_left;
                stq_pkg::RES_QUERY_IDLE: t_left = stq_pkg::TIME_ONES;
                stq_pkg::RES_FIRE: begin
                    f_fired = 1'b1;
                    f_id    = stq_pkg::ID_W'(r_order[0]);
                end
                default: ;
            endcase
            r_odata <= {4'b0000, t_next, t_left, f_id};
            r_ouser <= {f_sv, f_status, f_fired};
            r_olast <= (i_ctl.kind != stq_pkg::RES_FIRE);
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;
    assign o_m_axis_tlast  = r_olast;

endmodule

// ----- sv/sorted_timer_queue_scheduler.sv -----
// Top level of the sorted timer queue scheduler.
//
// The block keeps NUM_TIMERS one-shot timers in a list ordered by time left
// and takes one command per input transfer: start, cancel, query or tick.
// Start arms a timer (a timeout of zero or all-ones, or a slot outside the
// range, is rejected with status 1), cancel disarms it, query returns its
// time left, and tick fires the expired timers at the head of the list, one
// output transfer per fired timer in list order. Every command ends with
// exactly one output transfer that has tlast set; an accepted start, an
// effective cancel and tick report the new next wakeup there. Elapsed time
// is the current tick count minus the start time, modulo 2^32. Commands are
// handled one at a time: the input is ready again only after the final
// result of the last command has been loaded into the output register. Each
// list entry examined goes through the single read port of the timer
// memories and then the time-left unit behind it; a start compares at most
// NUM_TIMERS - 1 entries. A command also waits while the output side stalls.
module sorted_timer_queue_scheduler #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata: timer_id[3:0], timeout_ticks[35:4], current_time[67:36], zero pad
    input  logic [stq_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // tuser: command[1:0]
    input  logic [stq_pkg::IN_USER_W-1:0]      i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata: fired_id[3:0], remaining[35:4], next_wakeup[67:36], zero pad
    output logic [stq_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // tuser: fired[0], status[1], schedule_valid[2]
    output logic [stq_pkg::OUT_USER_W-1:0]     o_m_axis_tuser,
    output logic                               o_m_axis_tlast
);

    stq_pkg::t_ctl ctl;
    stq_pkg::t_sts sts;

    // The sequencer walks the list and decides; the datapath holds all state.
    stq_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_ctl           (ctl)
    );

    stq_dp #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_ctl           (ctl),
        .o_sts           (sts)
    );

endmodule

// ----- tb/timer_queue_checker.sv -----
`timescale 1ns / 100ps
// Checker that predicts and compares every output transfer of the timer queue scheduler.
module timer_queue_checker #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [stq_pkg::IN_DATA_W-1:0]  i_in_data,
    input  logic [stq_pkg::IN_USER_W-1:0]  i_in_user,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [stq_pkg::OUT_DATA_W-1:0] i_out_data,
    input  logic [stq_pkg::OUT_USER_W-1:0] i_out_user,
    input  logic                           i_out_last,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_result_count,
    output int                             o_fired_count
);

    typedef struct packed {
        logic                       fired;
        logic [stq_pkg::ID_W-1:0]   fired_id;
        logic                       status;
        logic [stq_pkg::TIME_W-1:0] remaining;
        logic                       sched;
        logic [stq_pkg::TIME_W-1:0] wakeup;
        logic                       last;
    } t_report;

    // Own copy of the timer state.
    logic                       armed    [NUM_TIMERS];
    logic [stq_pkg::TIME_W-1:0] armed_at [NUM_TIMERS];
    logic [stq_pkg::TIME_W-1:0] span     [NUM_TIMERS];
    logic [stq_pkg::ID_W-1:0]   run_order[NUM_TIMERS];
    int unsigned                armed_n;

    t_report pending_reports[$];
    int      n_mismatches = 0;
    int      n_results = 0;
    int      n_fired = 0;

    assign o_fail_count   = n_mismatches;
    assign o_result_count = n_results;
    assign o_fired_count  = n_fired;

    function automatic t_report make_report(logic fired, logic [stq_pkg::ID_W-1:0] fid,
                                            logic status,
                                            logic [stq_pkg::TIME_W-1:0] tleft, logic sched,
                                            logic [stq_pkg::TIME_W-1:0] next, logic last);
        t_report r;
        r.fired     = fired;
        r.fired_id  = fid;
        r.status    = status;
        r.remaining = tleft;
        r.sched     = sched;
        r.wakeup    = next;
        r.last      = last;
        return r;
    endfunction

    // Remaining ticks, with the elapsed time taken modulo 2^32.
    function automatic logic [stq_pkg::TIME_W-1:0] ticks_left_of(
        logic [stq_pkg::ID_W-1:0] slot, logic [stq_pkg::TIME_W-1:0] now);
        logic [stq_pkg::TIME_W-1:0] elapsed;
        elapsed = now - armed_at[slot];
        return (elapsed <= span[slot]) ? span[slot] - elapsed : '0;
    endfunction

    function automatic void disarm(logic [stq_pkg::ID_W-1:0] slot);
        int unsigned i;
        int unsigned keep;
        keep = 0;
        for (i = 0; i < armed_n; i++) begin
            if (run_order[i] != slot) begin
                run_order[keep] = run_order[i];
                keep++;
            end
        end
        armed_n = keep;
        armed[slot] = 1'b0;
        span[slot] = '0;
        armed_at[slot] = '0;
    endfunction

    function automatic logic [stq_pkg::TIME_W-1:0] head_wakeup(
        logic [stq_pkg::TIME_W-1:0] now);
        return (armed_n == 0) ? stq_pkg::TIME_ONES : ticks_left_of(run_order[0], now);
    endfunction

    function automatic void predict_command(stq_pkg::t_cmd cmd, logic [stq_pkg::ID_W-1:0] id,
                                            logic [stq_pkg::TIME_W-1:0] tmo,
                                            logic [stq_pkg::TIME_W-1:0] now);
        int unsigned                pos;
        int unsigned                i;
        logic [stq_pkg::ID_W-1:0]   slot;
        logic [stq_pkg::TIME_W-1:0] left;
        case (cmd)
            stq_pkg::CMD_START: begin
                if (tmo == '0 || tmo == stq_pkg::TIME_ONES || id >= NUM_TIMERS) begin
                    pending_reports.push_back(make_report(1'b0, '0, 1'b1, '0, 1'b0, '0, 1'b1));
                end else begin
                    if (armed[id]) disarm(id);
                    // The new timer goes behind every entry with less time left.
                    pos = 0;
                    while (pos < armed_n && ticks_left_of(run_order[pos], now) < tmo) pos++;
                    if (armed_n < NUM_TIMERS) begin
                        for (i = armed_n; i > pos; i--) run_order[i] = run_order[i-1];
                        run_order[pos] = id;
                        armed_n++;
                    end
                    armed[id] = 1'b1;
                    span[id] = tmo;
                    armed_at[id] = now;
                    pending_reports.push_back(make_report(1'b0, '0, 1'b0, '0, 1'b1,
                                                          head_wakeup(now), 1'b1));
                end
            end
            stq_pkg::CMD_CANCEL: begin
                if (id < NUM_TIMERS && armed[id]) begin
                    disarm(id);
                    pending_reports.push_back(make_report(1'b0, '0, 1'b0, '0, 1'b1,
                                                          head_wakeup(now), 1'b1));
                end else begin
                    pending_reports.push_back(make_report(1'b0, '0, 1'b0, '0, 1'b0, '0, 1'b1));
                end
            end
            stq_pkg::CMD_QUERY: begin
                left = (id < NUM_TIMERS && armed[id]) ? ticks_left_of(id, now)
                                                      : stq_pkg::TIME_ONES;
                pending_reports.push_back(make_report(1'b0, '0, 1'b0, left, 1'b0, '0, 1'b1));
            end
            default: begin
                // Tick: fire the expired prefix of the list in order.
                while (armed_n > 0) begin
                    slot = run_order[0];
                    if (ticks_left_of(slot, now) != '0) break;
                    disarm(slot);
                    pending_reports.push_back(make_report(1'b1, slot, 1'b0, '0, 1'b0, '0,
                                                          1'b0));
                end
                pending_reports.push_back(make_report(1'b0, '0, 1'b0, '0, 1'b1,
                                                      head_wakeup(now), 1'b1));
            end
        endcase
    endfunction

    function automatic void compare_result();
        t_report got;
        t_report want;
        got = make_report(i_out_user[0], i_out_data[3:0], i_out_user[1], i_out_data[35:4],
                          i_out_user[2], i_out_data[67:36], i_out_last);
        n_results++;
        if (pending_reports.size() == 0) begin
            n_mismatches++;
            if (n_mismatches <= 10)
                $display("Output transfer %0d arrived with no result outstanding", n_results);
            return;
        end
        want = pending_reports.pop_front();
        if (want.fired) n_fired++;
        if (got.fired !== want.fired || got.fired_id !== want.fired_id ||
            got.status !== want.status || got.remaining !== want.remaining ||
            got.sched !== want.sched || got.wakeup !== want.wakeup ||
            got.last !== want.last) begin
            n_mismatches++;
            if (n_mismatches <= 10) begin
                $display("Result %0d differs (expected/actual): fired %0d/%0d id %0d/%0d",
                         n_results, want.fired, got.fired, want.fired_id, got.fired_id);
                $display("  status %0d/%0d ticks left %h/%h schedule_valid %0d/%0d",
                         want.status, got.status, want.remaining, got.remaining,
                         want.sched, got.sched);
                $display("  next wakeup %h/%h last %0d/%0d",
                         want.wakeup, got.wakeup, want.last, got.last);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_TIMERS; s++) begin
                armed[s] = 1'b0;
                armed_at[s] = '0;
                span[s] = '0;
            end
            armed_n = 0;
            pending_reports.delete();
            o_pending <= 0;
        end else begin
            // Results leave before the next command enters; the queue keeps order either way.
            if (i_out_valid && i_out_ready) compare_result();
            if (i_in_valid && i_in_ready)
                predict_command(stq_pkg::t_cmd'(i_in_user[stq_pkg::CMD_W-1:0]),
                                i_in_data[3:0], i_in_data[35:4], i_in_data[67:36]);
            o_pending <= pending_reports.size();
        end
    end

endmodule

// ----- tb/sorted_timer_queue_scheduler_tb.sv -----
`timescale 1ns / 100ps
// Testbench top: drives timer commands into the scheduler and reports the verdict.
module sorted_timer_queue_scheduler_tb;

    localparam int NUM_TIMERS   = 16;
    // The slowest run stays far below this: about 330 commands, each at most
    // 17 results behind a stalling receiver, plus one long hold-off.
    localparam int LIMIT_CYCLES = 600000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 98;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_s_axis_tvalid;
    logic                           o_s_axis_tready;
    // tdata: timer_id[3:0], timeout_ticks[35:4], current_time[67:36], zero pad
    logic [stq_pkg::IN_DATA_W-1:0]  i_s_axis_tdata;
    // tuser: command[1:0]
    logic [stq_pkg::IN_USER_W-1:0]  i_s_axis_tuser;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready;
    // tdata: fired_id[3:0], remaining[35:4], next_wakeup[67:36], zero pad
    logic [stq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    // tuser: fired[0], status[1], schedule_valid[2]
    logic [stq_pkg::OUT_USER_W-1:0] o_m_axis_tuser;
    logic                           o_m_axis_tlast;

    int fail_count;
    int pending_count;
    int result_count;
    int fired_count;

    // Stimulus knobs shared between the sender and the receiver process.
    int unsigned                send_idle_pct;
    int unsigned                recv_idle_pct;
    int unsigned                hold_request = 0;
    int unsigned                hold_served = 0;
    int unsigned                cycle_count = 0;
    int unsigned                cmd_count[4] = '{0, 0, 0, 0};
    logic [stq_pkg::TIME_W-1:0] now_tick;

    sorted_timer_queue_scheduler #(
        .NUM_TIMERS(NUM_TIMERS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // The checker sees both channels exactly as the block does and keeps its
    // own model of the timer list; it only hands back counts.
    timer_queue_checker #(
        .NUM_TIMERS(NUM_TIMERS)
    ) timer_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_s_axis_tvalid),
        .i_in_ready     (o_s_axis_tready),
        .i_in_data      (i_s_axis_tdata),
        .i_in_user      (i_s_axis_tuser),
        .i_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .i_out_data     (o_m_axis_tdata),
        .i_out_user     (o_m_axis_tuser),
        .i_out_last     (o_m_axis_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count),
        .o_result_count (result_count),
        .o_fired_count  (fired_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Run stopped at the cycle limit with %0d results outstanding",
                     pending_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver side. It stalls at random, and when the sender asks for a
    // hold-off it keeps tready low for a long counted stretch so that the
    // output register fills and the block stops accepting commands.
    initial begin
        int unsigned hold_left;
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_request) begin
                hold_served = hold_request;
                i_m_axis_tready <= 1'b0;
                for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) @(posedge i_clk);
            end
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one command, idling first at the current rate, and returns at
    // the clock edge where the transfer happens. tvalid is left high so a
    // following command can go out back to back without a gap.
    task automatic send_command(stq_pkg::t_cmd cmd, logic [stq_pkg::ID_W-1:0] id,
                                logic [stq_pkg::TIME_W-1:0] tmo,
                                logic [stq_pkg::TIME_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0, now, tmo, id};
        i_s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
        cmd_count[cmd]++;
    endtask

    // Stops offering and waits until every predicted result has come out.
    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    // Random commands against a mostly advancing clock. Timeouts are kept
    // short so the list holds several timers and ticks fire real prefixes;
    // a few items use rejected timeouts, full-range values or a random time.
    task automatic random_commands(int unsigned count);
        int unsigned                n;
        int unsigned                pick;
        int unsigned                pick_id;
        logic [stq_pkg::ID_W-1:0]   id;
        logic [stq_pkg::TIME_W-1:0] tmo;
        logic [stq_pkg::TIME_W-1:0] now;
        for (n = 0; n < count; n++) begin
            pick    = $urandom_range(99);
            pick_id = $urandom_range(NUM_TIMERS - 1);
            id      = pick_id[stq_pkg::ID_W-1:0];
            tmo     = $urandom;
            now     = ($urandom_range(39) == 0) ? $urandom : now_tick;
            if (pick < 40) begin
                case ($urandom_range(24))
                    0:       tmo = '0;
                    1:       tmo = stq_pkg::TIME_ONES;
                    2, 3:    tmo = $urandom;
                    default: tmo = $urandom_range(250, 1);
                endcase
                send_command(stq_pkg::CMD_START, id, tmo, now);
            end else if (pick < 52) begin
                send_command(stq_pkg::CMD_CANCEL, id, tmo, now);
            end else if (pick < 66) begin
                send_command(stq_pkg::CMD_QUERY, id, tmo, now + $urandom_range(30));
            end else begin
                // Now and then the clock jumps close to the wrap point.
                if ($urandom_range(29) == 0)
                    now_tick = stq_pkg::TIME_ONES - $urandom_range(200);
                else
                    now_tick = now_tick + $urandom_range(90);
                send_command(stq_pkg::CMD_TICK, id, tmo, now_tick);
            end
        end
    endtask

    initial begin
        int unsigned id;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = stq_pkg::CMD_START;
        send_idle_pct   = 34;
        recv_idle_pct   = 52;
        now_tick        = 32'h0000_1000;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty list, rejected timeouts, restart of an armed
        // timer, a tie in time left, the largest valid timeout, cancel of an
        // armed and an idle timer, an overdue query and a tick across the wrap.
        send_command(stq_pkg::CMD_QUERY, 4'd0, 32'd0, now_tick);
        send_command(stq_pkg::CMD_CANCEL, 4'd15, stq_pkg::TIME_ONES, now_tick);
        send_command(stq_pkg::CMD_TICK, 4'd0, 32'd0, now_tick);
        send_command(stq_pkg::CMD_START, 4'd3, 32'd0, now_tick);
        send_command(stq_pkg::CMD_START, 4'd3, stq_pkg::TIME_ONES, now_tick);
        send_command(stq_pkg::CMD_START, 4'd0, 32'd1, now_tick);
        send_command(stq_pkg::CMD_START, 4'd15, 32'hFFFF_FFFE, now_tick);
        send_command(stq_pkg::CMD_START, 4'd5, 32'd100, now_tick);
        send_command(stq_pkg::CMD_START, 4'd5, 32'd50, now_tick + 5);
        send_command(stq_pkg::CMD_QUERY, 4'd5, 32'd0, now_tick + 15);
        // Same time left as slot 5, so it must go in front of it.
        send_command(stq_pkg::CMD_START, 4'd7, 32'd40, now_tick + 15);
        send_command(stq_pkg::CMD_QUERY, 4'd15, 32'd0, now_tick + 15);
        send_command(stq_pkg::CMD_CANCEL, 4'd15, 32'd0, now_tick + 15);
        send_command(stq_pkg::CMD_TICK, 4'd0, 32'd0, now_tick + 16);
        send_command(stq_pkg::CMD_QUERY, 4'd0, 32'd0, now_tick + 16);
        send_command(stq_pkg::CMD_QUERY, 4'd7, 32'd0, now_tick + 200);
        send_command(stq_pkg::CMD_START, 4'd3, 32'd5, 32'hFFFF_FFFD);
        send_command(stq_pkg::CMD_TICK, 4'd15, stq_pkg::TIME_ONES, 32'h0000_0002);
        now_tick = 32'h0000_0100;
        wait_for_results();

        // Phase one: the sender idles a third of the time, the receiver half.
        random_commands(PHASE_ITEMS);

        // Back pressure: the receiver holds off while all sixteen timers are
        // restarted and then fired by one tick, the longest result burst.
        hold_request = hold_request + 1;
        for (id = 0; id < NUM_TIMERS; id++)
            send_command(stq_pkg::CMD_START, id[stq_pkg::ID_W-1:0],
                         32'd10 + (id * 7) % 13, now_tick);
        now_tick = now_tick + 40;
        send_command(stq_pkg::CMD_TICK, 4'd0, 32'd0, now_tick);
        wait_for_results();

        // Phase two swaps the idle rates, phase three runs without idling.
        send_idle_pct = 52;
        recv_idle_pct = 34;
        random_commands(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_commands(PHASE_ITEMS);

        wait_for_results();
        repeat (40) @(posedge i_clk);

        $display("Covered %0d commands: %0d start, %0d cancel, %0d query, %0d tick.",
                 cmd_count[stq_pkg::CMD_START] + cmd_count[stq_pkg::CMD_CANCEL]
                 + cmd_count[stq_pkg::CMD_QUERY] + cmd_count[stq_pkg::CMD_TICK],
                 cmd_count[stq_pkg::CMD_START], cmd_count[stq_pkg::CMD_CANCEL],
                 cmd_count[stq_pkg::CMD_QUERY], cmd_count[stq_pkg::CMD_TICK]);
        $display("Checked %0d results, %0d of them fired timers, %0d mismatches.",
                 result_count, fired_count, fail_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
